// ===== src/sdbc_pkg.sv =====
`default_nettype none
package sdbc_pkg;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_ALLOC,
        ST_OUT
    } sdbc_state_t;

    // free queue command
    typedef struct packed {
        logic push;
        logic pop;
    } fq_cmd_t;

    localparam logic        REG_AGE_LIMIT    = 1'b0;
    localparam logic        REG_LOCAL_BASE   = 1'b1;
    localparam logic        FUNC_LOOKUP      = 1'b0;
    localparam logic        FUNC_TICK        = 1'b1;
    localparam logic [3:0]  AGE_LIMIT_RESET  = 4'd2;
    localparam logic [15:0] LOCAL_BASE_RESET = 16'hC000;
    localparam logic [31:0] ALIGN_MASK       = 32'h0000_0003;

endpackage
`default_nettype wire

// ===== src/sdbc_if.sv =====
`default_nettype none
interface sdbc_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] sample_addr;
    logic [8:0]  span_len;

    modport source (output valid, func, sample_addr, span_len, input ready);
    modport sink   (input valid, func, sample_addr, span_len, output ready);
endinterface

interface sdbc_out_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [15:0] local_addr;
    logic        dma_go;
    logic [31:0] dma_src;
    logic        no_free;

    modport source (output valid, hit, local_addr, dma_go, dma_src, no_free, input ready);
    modport sink   (input valid, hit, local_addr, dma_go, dma_src, no_free, output ready);
endinterface
`default_nettype wire

// ===== src/sdbc_entry_mem.sv =====
`default_nettype none
module sdbc_entry_mem #(
    parameter int ENTRIES = 8
) (
    input  wire logic                       clk,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(ENTRIES)-1:0] rd_idx,
    output logic [47:0]                     rd_data,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(ENTRIES)-1:0] wr_idx,
    input  wire logic [47:0]                wr_data
);
    // {start[31:0], stamp[15:0]} per buffer
    logic [47:0] mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_idx];
        end
    end
endmodule
`default_nettype wire

// ===== src/sdbc_free_queue.sv =====
`default_nettype none
module sdbc_free_queue #(
    parameter int ENTRIES = 8
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire sdbc_pkg::fq_cmd_t            cmd,
    input  wire logic [$clog2(ENTRIES)-1:0]   push_idx,
    output logic [$clog2(ENTRIES)-1:0]        head_data,
    output logic [$clog2(ENTRIES+1)-1:0]      count,
    output logic                              init_done
);
    import sdbc_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [IDX_W-1:0] mem [ENTRIES];
    logic [IDX_W-1:0] head_reg;
    logic [CNT_W-1:0] count_reg;
    logic             init_reg;
    logic [IDX_W-1:0] init_idx_reg;
    logic [IDX_W:0]   tail_sum;
    logic [IDX_W-1:0] tail;

    assign tail_sum  = {1'b0, head_reg} + (IDX_W+1)'(count_reg);
    assign tail      = (tail_sum >= (IDX_W+1)'(ENTRIES)) ?
                       IDX_W'(tail_sum - (IDX_W+1)'(ENTRIES)) : tail_sum[IDX_W-1:0];
    assign count     = count_reg;
    assign init_done = !init_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            count_reg    <= CNT_W'(ENTRIES);
            init_reg     <= 1'b1;
            init_idx_reg <= '0;
        end
        else if (init_reg)
        begin
            init_idx_reg <= init_idx_reg + 1'b1;
            if (init_idx_reg == IDX_W'(ENTRIES - 1))
            begin
                init_reg <= 1'b0;
            end
        end
        else if (cmd.pop)
        begin
            head_reg  <= (head_reg == IDX_W'(ENTRIES - 1)) ? '0 : head_reg + 1'b1;
            count_reg <= count_reg - 1'b1;
        end
        else if (cmd.push)
        begin
            count_reg <= count_reg + 1'b1;
        end
    end

    // clearing pass loads 0..ENTRIES-1; afterwards tail writes and head reads
    always_ff @(posedge clk)
    begin
        if (init_reg)
        begin
            mem[init_idx_reg] <= init_idx_reg;
        end
        else if (cmd.push)
        begin
            mem[tail] <= push_idx;
        end
        if (cmd.pop)
        begin
            head_data <= mem[head_reg];
        end
    end
endmodule
`default_nettype wire

// ===== src/sample_dma_buffer_cache.sv =====
// sample_dma_buffer_cache
// Cache of ENTRIES local buffers, BUF_WORDS words each, mirroring external
// sample memory. Items arrive on in_ch (func, sample_addr, span_len); every
// item yields exactly one transfer on out_ch (hit, local_addr, dma_go,
// dma_src, no_free). A lookup returns the covering buffer's local address,
// else allocates the free-queue head and asks for a DMA fill, else flags
// no_free; a frame tick bumps the frame counter and frees idle buffers.
// One item at a time: a new item is taken only after the last one's result
// has gone to the output register. The cost is the one-entry-per-cycle scan
// through the buffer-tag memory's single read port.
// Reset: all buffers free, frame 0, registers at defaults; then a clearing
// pass loads the free queue, during which in_ch.ready is low (APB writes
// still taken). If out_ch stalls, the result waits in the output register;
// the next item is still taken and worked on, but it holds in ST_OUT, with
// in_ch.ready low, until the register drains.
// APB: age_limit at 0x0, local_base at 0x4; pready is always high.
`default_nettype none
module sample_dma_buffer_cache #(
    parameter int ENTRIES   = 8,
    parameter int BUF_WORDS = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    sdbc_in_if.sink          in_ch,
    sdbc_out_if.source       out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import sdbc_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    sdbc_state_t      state_reg, state_next;

    // config
    logic [3:0]       age_limit_reg;
    logic [15:0]      local_base_reg;

    // cache state
    logic [ENTRIES-1:0] used_reg;
    logic [15:0]      frame_reg;

    // item under work
    logic             func_reg;
    logic [31:0]      addr_reg;
    logic [8:0]       len_reg;

    // scan
    logic [CNT_W-1:0] cnt_reg;
    logic             dv_reg;
    logic [IDX_W-1:0] didx_reg;
    logic             found_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [31:0]      best_start_reg;

    // result
    logic             res_hit_reg, res_dma_reg, res_nofree_reg;
    logic [15:0]      res_local_reg;
    logic [31:0]      res_src_reg;

    logic             out_valid_reg;
    logic             out_hit_reg, out_dma_reg, out_nofree_reg;
    logic [15:0]      out_local_reg;
    logic [31:0]      out_src_reg;

    // memory and queue hookup
    logic             m_rd_en;
    logic [47:0]      m_rdata;
    logic             m_wr_en;
    logic [IDX_W-1:0] m_wr_idx;
    logic [47:0]      m_wr_data;
    fq_cmd_t          q_cmd;
    logic [IDX_W-1:0] q_head;
    logic [CNT_W-1:0] q_count;
    logic             q_ready;

    logic             in_xfer, out_xfer, cfg_wr, scan_issue;
    logic [31:0]      e_start;
    logic [15:0]      e_stamp;
    logic [15:0]      e_age;
    logic             e_covers, e_better, e_expire;
    logic [15:0]      hit_local, alloc_local;
    logic [31:0]      aligned_addr;

    sdbc_entry_mem #(.ENTRIES(ENTRIES)) u_mem (
        .clk     (clk),
        .rd_en   (m_rd_en),
        .rd_idx  (cnt_reg[IDX_W-1:0]),
        .rd_data (m_rdata),
        .wr_en   (m_wr_en),
        .wr_idx  (m_wr_idx),
        .wr_data (m_wr_data)
    );

    sdbc_free_queue #(.ENTRIES(ENTRIES)) u_fq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_cmd),
        .push_idx  (didx_reg),
        .head_data (q_head),
        .count     (q_count),
        .init_done (q_ready)
    );

    // ---------------- APB ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_LOCAL_BASE) ? {16'b0, local_base_reg}
                                                 : {28'b0, age_limit_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_limit_reg  <= AGE_LIMIT_RESET;
            local_base_reg <= LOCAL_BASE_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_AGE_LIMIT)
            begin
                age_limit_reg <= pwdata[3:0];
            end
            else
            begin
                local_base_reg <= pwdata[15:0];
            end
        end
    end

    // ---------------- handshakes ----------------
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign out_xfer    = out_valid_reg && out_ch.ready;

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.hit        = out_hit_reg;
    assign out_ch.local_addr = out_local_reg;
    assign out_ch.dma_go     = out_dma_reg;
    assign out_ch.dma_src    = out_src_reg;
    assign out_ch.no_free    = out_nofree_reg;

    // ---------------- scan evaluation ----------------
    assign scan_issue = (state_reg == ST_SCAN) && (cnt_reg < CNT_W'(ENTRIES));
    assign m_rd_en    = scan_issue;
    assign e_start    = m_rdata[47:16];
    assign e_stamp    = m_rdata[15:0];
    assign e_age      = frame_reg - e_stamp;
    // coverage without wrap: 33-bit sums
    assign e_covers   = used_reg[didx_reg] && (e_start <= addr_reg) &&
                        (({1'b0, addr_reg} + 33'(len_reg)) <=
                         ({1'b0, e_start} + 33'(BUF_WORDS)));
    assign e_better   = !found_reg || (e_start < best_start_reg);
    assign e_expire   = used_reg[didx_reg] && (e_age > {12'b0, age_limit_reg});

    assign aligned_addr = addr_reg & ~ALIGN_MASK;
    assign hit_local    = local_base_reg + 16'(best_idx_reg * BUF_WORDS)
                        + 16'(addr_reg - best_start_reg);
    assign alloc_local  = local_base_reg + 16'(q_head * BUF_WORDS)
                        + 16'(addr_reg & ALIGN_MASK);

    // ---------------- control ----------------
    always_comb
    begin
        state_next = state_reg;
        q_cmd      = '0;
        m_wr_en    = 1'b0;
        m_wr_idx   = best_idx_reg;
        m_wr_data  = {best_start_reg, frame_reg};
        case (state_reg)
            ST_INIT:
            begin
                if (q_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // tick frees in ascending order as the scan walks up
                q_cmd.push = dv_reg && (func_reg == FUNC_TICK) && e_expire;
                if (!scan_issue && !dv_reg)
                begin
                    state_next = (func_reg == FUNC_TICK) ? ST_OUT : ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (found_reg)
                begin
                    m_wr_en    = 1'b1;
                    state_next = ST_OUT;
                end
                else if (q_count == '0)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    q_cmd.pop  = 1'b1;
                    state_next = ST_ALLOC;
                end
            end
            ST_ALLOC:
            begin
                m_wr_en    = 1'b1;
                m_wr_idx   = q_head;
                m_wr_data  = {aligned_addr, frame_reg};
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control state: scan bookkeeping, valid bits, frame, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            frame_reg     <= '0;
            cnt_reg       <= '0;
            dv_reg        <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            dv_reg <= scan_issue;
            if (in_xfer)
            begin
                cnt_reg   <= '0;
                found_reg <= 1'b0;
                if (in_ch.func == FUNC_TICK)
                begin
                    frame_reg <= frame_reg + 1'b1;
                end
            end
            if (scan_issue)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (state_reg == ST_SCAN && dv_reg)
            begin
                if (func_reg == FUNC_TICK)
                begin
                    if (e_expire)
                    begin
                        used_reg[didx_reg] <= 1'b0;
                    end
                end
                else if (e_covers && e_better)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (state_reg == ST_ALLOC)
            begin
                used_reg[q_head] <= 1'b1;
            end
            if (state_reg == ST_OUT && (!out_valid_reg || out_ch.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_xfer)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            func_reg       <= in_ch.func;
            addr_reg       <= in_ch.sample_addr;
            len_reg        <= in_ch.span_len;
            res_hit_reg    <= 1'b0;
            res_dma_reg    <= 1'b0;
            res_nofree_reg <= 1'b0;
            res_local_reg  <= '0;
            res_src_reg    <= '0;
        end
        if (scan_issue)
        begin
            didx_reg <= cnt_reg[IDX_W-1:0];
        end
        if (state_reg == ST_SCAN && dv_reg && func_reg == FUNC_LOOKUP &&
            e_covers && e_better)
        begin
            best_idx_reg   <= didx_reg;
            best_start_reg <= e_start;
        end
        if (state_reg == ST_DECIDE)
        begin
            if (found_reg)
            begin
                res_hit_reg   <= 1'b1;
                res_local_reg <= hit_local;
            end
            else if (q_count == '0)
            begin
                res_nofree_reg <= 1'b1;
            end
        end
        if (state_reg == ST_ALLOC)
        begin
            res_dma_reg   <= 1'b1;
            res_src_reg   <= aligned_addr;
            res_local_reg <= alloc_local;
        end
        if (state_reg == ST_OUT && (!out_valid_reg || out_ch.ready))
        begin
            out_hit_reg    <= res_hit_reg;
            out_local_reg  <= res_local_reg;
            out_dma_reg    <= res_dma_reg;
            out_src_reg    <= res_src_reg;
            out_nofree_reg <= res_nofree_reg;
        end
    end
endmodule
`default_nettype wire

// ===== sim/sample_dma_buffer_cache_tb.sv =====
`timescale 1ns / 1ps
module sample_dma_buffer_cache_tb;
    import sdbc_pkg::*;

    localparam int NBUF  = 8;
    localparam int BWORDS = 256;
    localparam int STALL_LIMIT = 4000;  // cycles with no transfer before giving up

    typedef struct packed {
        bit        hit;
        bit [15:0] local_addr;
        bit        dma_go;
        bit [31:0] dma_src;
        bit        no_free;
    } cache_result_t;

    // Mirror of the buffer tags, free order and frame counter; every accepted
    // item pushes its expected result, every output transfer pops one.
    class cache_scoreboard;
        bit            used [NBUF];
        bit [31:0]     start [NBUF];
        bit [15:0]     stamp [NBUF];
        bit [2:0]      order [NBUF];
        int            free_n;
        bit [15:0]     frame;
        bit [3:0]      age_lim;
        bit [15:0]     base;
        cache_result_t pending[$];
        int            errors;

        function new();
            for (int i = 0; i < NBUF; i++)
            begin
                used[i]  = 0;
                start[i] = 0;
                stamp[i] = 0;
                order[i] = i[2:0];
            end
            free_n  = NBUF;
            frame   = 0;
            age_lim = AGE_LIMIT_RESET;
            base    = LOCAL_BASE_RESET;
            errors  = 0;
        endfunction

        function void note_input(bit f, bit [31:0] addr, bit [8:0] len);
            cache_result_t r;
            int            sel;
            bit            found;
            bit [15:0]     age;
            r = '{0, 0, 0, 0, 0};
            sel = 0;
            found = 0;
            if (f == FUNC_TICK)
            begin
                frame = frame + 16'd1;
                for (int i = 0; i < NBUF; i++)
                begin
                    age = frame - stamp[i];
                    if (used[i] && age > age_lim && free_n < NBUF)
                    begin
                        used[i] = 0;
                        order[free_n] = i[2:0];
                        free_n++;
                    end
                end
            end
            else
            begin
                // coverage is checked in 33 bits so spans near the top never wrap
                for (int i = 0; i < NBUF; i++)
                begin
                    if (!used[i] || start[i] > addr)
                        continue;
                    if ({1'b0, addr} + 33'(len) > {1'b0, start[i]} + 33'(BWORDS))
                        continue;
                    if (!found || start[i] < start[sel])
                    begin
                        sel = i;
                        found = 1;
                    end
                end
                if (found)
                begin
                    stamp[sel] = frame;
                    r.hit = 1;
                    r.local_addr = base + 16'(sel * BWORDS) + 16'(addr - start[sel]);
                end
                else if (free_n == 0)
                    r.no_free = 1;
                else
                begin
                    sel = order[0];
                    for (int i = 0; i < NBUF - 1; i++)
                        order[i] = order[i + 1];
                    order[NBUF - 1] = 0;
                    free_n--;
                    used[sel]  = 1;
                    start[sel] = addr & ~ALIGN_MASK;
                    stamp[sel] = frame;
                    r.local_addr = base + 16'(sel * BWORDS) + 16'(addr & ALIGN_MASK);
                    r.dma_go = 1;
                    r.dma_src = start[sel];
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(cache_result_t got);
            cache_result_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result hit=%0d local_addr=%h", got.hit,
                             got.local_addr);
                return;
            end
            want = pending.pop_front();
            if (got != want)
            begin
                errors++;
                if (errors <= 10)
                    $display({"ERROR: exp hit=%0d la=%h go=%0d src=%h nf=%0d, ",
                              "got hit=%0d la=%h go=%0d src=%h nf=%0d"},
                             want.hit, want.local_addr, want.dma_go, want.dma_src,
                             want.no_free, got.hit, got.local_addr, got.dma_go,
                             got.dma_src, got.no_free);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sdbc_in_if  in_ch ();
    sdbc_out_if out_ch ();

    sample_dma_buffer_cache DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    cache_scoreboard sb;
    int in_idle_pct;        // sender gap chance per cycle, percent
    int out_stall_pct;      // receiver stall chance per cycle, percent
    int hold_left;          // long receiver hold-off, cycles remaining
    int quiet_cycles;
    bit [31:0] region;      // window the random lookups cluster in

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // Receiver: random back-pressure, plus the long hold-off when requested.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // Monitor on the result side; samples before this edge's updates land.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result('{out_ch.hit, out_ch.local_addr, out_ch.dma_go,
                              out_ch.dma_src, out_ch.no_free});
    end

    // Watchdog: any transfer on either channel resets the count.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // APB write: setup cycle, then access cycle; pready is tied high.
    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == {REG_AGE_LIMIT, 2'b00})
            sb.age_lim = data[3:0];
        else if (addr == {REG_LOCAL_BASE, 2'b00})
            sb.base = data[15:0];
    endtask

    // One item: optional gap, then hold valid until the transfer happens.
    task automatic send_item(logic f, logic [31:0] addr, logic [8:0] len);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.func        <= f;
        in_ch.sample_addr <= addr;
        in_ch.span_len    <= len;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_input(f, addr, len);
    endtask

    // Wait until every expected result is back, then let the block settle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // Random traffic: mostly lookups clustered in a 2K window so buffers
    // get reused, some ticks to age them out, a few wild addresses and
    // long spans.
    task automatic random_items(int n);
        logic [31:0] addr;
        logic [8:0]  len;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(99) < 12)
                send_item(FUNC_TICK, $urandom, 9'($urandom));
            else
            begin
                if ($urandom_range(99) < 10)
                    addr = $urandom;
                else
                    addr = region + $urandom_range(2047);
                if ($urandom_range(99) < 6)
                    len = 9'($urandom_range(511, 257));
                else
                    len = 9'($urandom_range(256));
                send_item(FUNC_LOOKUP, addr, len);
            end
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        in_ch.valid = 0;
        in_ch.func = FUNC_LOOKUP;
        in_ch.sample_addr = 0;
        in_ch.span_len = 0;
        out_ch.ready = 0;
        hold_left = 0;
        quiet_cycles = 0;
        in_idle_pct = 0;
        out_stall_pct = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at reset settings: zero and full spans, ties on equal
        // starts, long spans, top of the address space, full cache, ageing.
        send_item(FUNC_LOOKUP, 32'h0000_0000, 9'd0);
        send_item(FUNC_LOOKUP, 32'h0000_0000, 9'd256);
        send_item(FUNC_LOOKUP, 32'h0000_0001, 9'd255);
        send_item(FUNC_LOOKUP, 32'h0000_0001, 9'd256);
        send_item(FUNC_LOOKUP, 32'h0000_0002, 9'd100);
        send_item(FUNC_LOOKUP, 32'h0000_1003, 9'd257);
        send_item(FUNC_LOOKUP, 32'h0000_1003, 9'd511);
        send_item(FUNC_LOOKUP, 32'hFFFF_FFFF, 9'd0);
        send_item(FUNC_LOOKUP, 32'hFFFF_FFFF, 9'd256);
        send_item(FUNC_LOOKUP, 32'hFFFF_FFFC, 9'd3);
        send_item(FUNC_LOOKUP, 32'h8000_0000, 9'd1);
        send_item(FUNC_LOOKUP, 32'h5555_5555, 9'd170);
        send_item(FUNC_LOOKUP, 32'hAAAA_AAAA, 9'd85);
        send_item(FUNC_LOOKUP, 32'h0000_2000, 9'd4);
        send_item(FUNC_TICK, 32'hFFFF_FFFF, 9'h1FF);
        send_item(FUNC_LOOKUP, 32'h0000_0010, 9'd8);
        send_item(FUNC_TICK, 32'h0, 9'd0);
        send_item(FUNC_TICK, 32'h0, 9'd0);
        send_item(FUNC_LOOKUP, 32'h0000_3000, 9'd16);
        send_item(FUNC_TICK, 32'h0, 9'd0);
        send_item(FUNC_LOOKUP, 32'h0000_0020, 9'd16);
        drain();

        // Four idling phases, each with its own register setting.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin reg_write({REG_AGE_LIMIT, 2'b00}, 32'd0);
                         reg_write({REG_LOCAL_BASE, 2'b00}, 32'h0000_0000); end
                1: begin reg_write({REG_AGE_LIMIT, 2'b00}, 32'd15);
                         reg_write({REG_LOCAL_BASE, 2'b00}, 32'h0000_FFFF); end
                2: begin reg_write({REG_AGE_LIMIT, 2'b00}, 32'd1);
                         reg_write({REG_LOCAL_BASE, 2'b00}, $urandom); end
                default: begin reg_write({REG_AGE_LIMIT, 2'b00}, $urandom_range(15, 1));
                         reg_write({REG_LOCAL_BASE, 2'b00}, 32'(LOCAL_BASE_RESET)); end
            endcase
            in_idle_pct   = (ph == 1) ? 53 : (ph == 3) ? 31 : 0;
            out_stall_pct = (ph == 2) ? 53 : (ph == 3) ? 31 : 0;
            region = (ph == 1) ? 32'hFFFF_F800 : $urandom & ~32'h7FF;
            if (ph == 0)
                hold_left = 300;  // block fills and must stall its input
            random_items(120);
            in_idle_pct = 0;      // a stretch with no gaps on the sender
            random_items(30);
            in_idle_pct   = (ph == 1) ? 53 : (ph == 3) ? 31 : 0;
            random_items(100);
            drain();
        end

        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== files.f =====
src/sdbc_pkg.sv
src/sdbc_if.sv
src/sdbc_entry_mem.sv
src/sdbc_free_queue.sv
src/sample_dma_buffer_cache.sv
sim/sample_dma_buffer_cache_tb.sv
